### rtl/assert_macros.svh
// Assertion macros shared by the RTL of the steering controller.
// Depends on nothing; included by modules that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clk edge outside of reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Implication checked on every rising clk edge outside of reset.
`define ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication checked outside of reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/cips_pkg.sv
// Types, register indexes and saturation helper for the cascaded PD steering block.
// No dependencies; imported by cascaded_incremental_pd_steering.
`timescale 1ns / 1ps

package cips_pkg;

  typedef logic signed [31:0] word_t;

  localparam int CFG_IDX_W = 3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_OUTER_TARGET = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KP_OUTER     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KD_OUTER     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KP_INNER     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_KD_INNER     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SERVO_CENTER = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SERVO_UPPER  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SERVO_LOWER  = 3'd7;

  // reset values
  localparam word_t       RST_OUTER_TARGET = 32'sd0;
  localparam word_t       RST_KP_OUTER     = 32'sd196608;
  localparam word_t       RST_KD_OUTER     = 32'sd0;
  localparam word_t       RST_KP_INNER     = 32'sd898;
  localparam word_t       RST_KD_INNER     = 32'sd0;
  localparam logic [30:0] RST_SERVO_CENTER = 31'd451543;
  localparam logic [30:0] RST_SERVO_UPPER  = 31'd494797;
  localparam logic [30:0] RST_SERVO_LOWER  = 31'd409600;

  // inner error limit in whole units
  localparam int INNER_ERR_LIM = 50;

  localparam logic signed [63:0] S32_MAX = 64'sd2147483647;
  localparam logic signed [63:0] S32_MIN = -64'sd2147483648;

  // saturate a wide signed value to the 32 bit signed range
  function automatic word_t sat32(input logic signed [63:0] v);
    word_t r;
    if (v > S32_MAX) begin
      r = 32'sh7fffffff;
    end else if (v < S32_MIN) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

### rtl/cascaded_incremental_pd_steering.sv
// Cascaded incremental PD steering: outer command loop feeding an inner steering loop.
// Requests are processed one at a time: a new request is taken only once the previous one
// has loaded its result, as the single shared 32x32 multiplier does four products per request.
// The block takes a new request while the previous result still waits for out_ready.
// Synchronous active-high rst restores register defaults and clears all loop state.
// Depends on cips_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cascaded_incremental_pd_steering
  import cips_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  // request channel
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic signed [31:0]          inner_measure,
  input  logic signed [31:0]          outer_measure,
  // result channel
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [30:0]                 servo_duty,
  output logic signed [31:0]          outer_command,
  output logic                        at_limit,
  // configuration write port
  input  logic                        cfg_we,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [31:0]                 cfg_data
);

  // inner error history width: +-(50 << FRAC_BITS) plus sign
  localparam int IE_W = FRAC_BITS + 7;
  localparam logic signed [32:0] ERR_LIM = 33'(INNER_ERR_LIM) <<< FRAC_BITS;

  // sequencer codes
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DIFF = 3'd1;
  localparam logic [2:0] ST_MUL1 = 3'd2;
  localparam logic [2:0] ST_MUL2 = 3'd3;
  localparam logic [2:0] ST_ADD  = 3'd4;
  localparam logic [2:0] ST_UPD  = 3'd5;
  localparam logic [2:0] ST_ERRI = 3'd6;
  localparam logic [2:0] ST_DONE = 3'd7;

  // configuration registers
  word_t       outer_target, kp_outer, kd_outer, kp_inner, kd_inner;
  logic [30:0] servo_center, servo_upper, servo_lower;

  // loop state
  word_t                   outer_accum, outer_err_prev, outer_err_prev2;
  logic signed [IE_W-1:0]  inner_err_prev, inner_err_prev2;
  word_t                   steer_offset;

  // datapath registers
  logic [2:0]              state, state_next;
  logic                    inner_loop;
  word_t                   inner_m;
  word_t                   cur_err;
  word_t                   d1, d2;
  logic signed [63:0]      prod;
  logic signed [63:0]      sum;
  logic signed [63:0]      st_sum;

  // combinational
  logic                    accept, out_load;
  word_t                   e1, e2, d1_next, d2_next;
  word_t                   mul_a, mul_b;
  logic signed [63:0]      term;
  word_t                   eo_next;
  logic signed [32:0]      ei_raw, ei_clamp;
  word_t                   hi, lo;
  logic signed [63:0]      st1, st2;
  logic                    clamp_hi, clamp_lo;
  word_t                   st_fin;

  assign accept   = in_valid && in_ready;
  assign in_ready = (state == ST_IDLE);
  assign out_load = (state == ST_DONE) && (!out_valid || out_ready);

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      outer_target <= RST_OUTER_TARGET;
      kp_outer     <= RST_KP_OUTER;
      kd_outer     <= RST_KD_OUTER;
      kp_inner     <= RST_KP_INNER;
      kd_inner     <= RST_KD_INNER;
      servo_center <= RST_SERVO_CENTER;
      servo_upper  <= RST_SERVO_UPPER;
      servo_lower  <= RST_SERVO_LOWER;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_OUTER_TARGET: outer_target <= cfg_data;
        REG_KP_OUTER:     kp_outer     <= cfg_data;
        REG_KD_OUTER:     kd_outer     <= cfg_data;
        REG_KP_INNER:     kp_inner     <= cfg_data;
        REG_KD_INNER:     kd_inner     <= cfg_data;
        REG_SERVO_CENTER: servo_center <= cfg_data[30:0];
        REG_SERVO_UPPER:  servo_upper  <= cfg_data[30:0];
        REG_SERVO_LOWER:  servo_lower  <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  // outer error, saturated
  assign eo_next = sat32(64'(outer_target) - 64'(outer_measure));

  // shared difference unit: first and second difference of the active loop
  assign e1 = inner_loop ? 32'(inner_err_prev)  : outer_err_prev;
  assign e2 = inner_loop ? 32'(inner_err_prev2) : outer_err_prev2;
  assign d1_next = sat32(64'(cur_err) - 64'(e1));
  assign d2_next = sat32(64'(cur_err) - (64'(e1) <<< 1) + 64'(e2));

  // shared multiplier operands
  always_comb begin
    if (state == ST_MUL1) begin
      mul_a = inner_loop ? kp_inner : kp_outer;
      mul_b = d1;
    end else begin
      mul_a = inner_loop ? kd_inner : kd_outer;
      mul_b = d2;
    end
  end

  // floor shift of the last product
  assign term = prod >>> FRAC_BITS;

  // inner error: measure minus command, clamped to the limit
  assign ei_raw = 33'(inner_m) - 33'(outer_accum);
  always_comb begin
    if (ei_raw > ERR_LIM) begin
      ei_clamp = ERR_LIM;
    end else if (ei_raw < -ERR_LIM) begin
      ei_clamp = -ERR_LIM;
    end else begin
      ei_clamp = ei_raw;
    end
  end

  // offset limits, upper clamp first then lower
  assign hi = $signed({1'b0, servo_upper}) - $signed({1'b0, servo_center});
  assign lo = $signed({1'b0, servo_lower}) - $signed({1'b0, servo_center});
  assign clamp_hi = st_sum > 64'(hi);
  assign st1      = clamp_hi ? 64'(hi) : st_sum;
  assign clamp_lo = st1 < 64'(lo);
  assign st2      = clamp_lo ? 64'(lo) : st1;
  assign st_fin   = st2[31:0];

  // sequencer
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (accept) state_next = ST_DIFF;
      ST_DIFF: state_next = ST_MUL1;
      ST_MUL1: state_next = ST_MUL2;
      ST_MUL2: state_next = ST_ADD;
      ST_ADD:  state_next = ST_UPD;
      ST_UPD:  state_next = inner_loop ? ST_DONE : ST_ERRI;
      ST_ERRI: state_next = ST_DIFF;
      ST_DONE: if (out_load) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // control and loop state
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      inner_loop      <= 1'b0;
      out_valid       <= 1'b0;
      outer_accum     <= '0;
      outer_err_prev  <= '0;
      outer_err_prev2 <= '0;
      inner_err_prev  <= '0;
      inner_err_prev2 <= '0;
      steer_offset    <= '0;
    end else begin
      state <= state_next;
      // result valid: set on load, cleared on handshake
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: if (accept) inner_loop <= 1'b0;
        ST_UPD: begin
          if (inner_loop) begin
            inner_err_prev2 <= inner_err_prev;
            inner_err_prev  <= cur_err[IE_W-1:0];
          end else begin
            outer_accum     <= sat32(64'(outer_accum) + sum);
            outer_err_prev2 <= outer_err_prev;
            outer_err_prev  <= cur_err;
          end
        end
        ST_ERRI: inner_loop <= 1'b1;
        ST_DONE: begin
          if (out_load) begin
            steer_offset <= st_fin;
          end
        end
        default: ;
      endcase
    end
  end

  // payload path
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (accept) begin
          inner_m <= inner_measure;
          cur_err <= eo_next;
        end
      end
      ST_DIFF: begin
        d1 <= d1_next;
        d2 <= d2_next;
      end
      ST_MUL1: prod <= mul_a * mul_b;
      ST_MUL2: begin
        sum  <= term;
        prod <= mul_a * mul_b;
      end
      ST_ADD:  sum <= sum + term;
      ST_UPD:  st_sum <= 64'(steer_offset) + sum;
      ST_ERRI: cur_err <= ei_clamp[31:0];
      ST_DONE: begin
        if (out_load) begin
          servo_duty    <= st_fin[30:0] + servo_center;
          outer_command <= outer_accum;
          at_limit      <= clamp_hi || clamp_lo;
        end
      end
      default: ;
    endcase
  end

  // checks
  `ASSERT_NEXT(a_accept_starts_outer, accept, (state == ST_DIFF) && !inner_loop, "accept did not start the outer loop")
  `ASSERT_NEXT(a_done_loads_result, out_load, out_valid && (state == ST_IDLE), "finished request did not produce a result")
  `ASSERT_NEXT(a_accum_only_in_update, !((state == ST_UPD) && !inner_loop), $stable(outer_accum), "outer accumulator changed outside its update step")
  `ASSERT_IMPLY(a_duty_above_lower, out_valid, servo_duty >= servo_lower, "servo duty below lower limit")

endmodule
